// File: src/stpf_pkg.sv
// Package for the serial transmit packet framer: item types, configuration
// struct, mode and register codes, header letters and framing constants.
// No dependencies.
package stpf_pkg;

  // Default transmit buffer size in bytes.
  localparam int unsigned BufferBytesDef = 256;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Header letters and framing lengths.
  localparam logic [7:0] ChrL = 8'h4C;
  localparam logic [7:0] ChrQ = 8'h51;
  localparam logic [7:0] ChrX = 8'h58;
  localparam logic [7:0] ChrM = 8'h4D;
  localparam logic [7:0] ChrA = 8'h41;

  localparam int unsigned ShortPktLen = 34;
  localparam int unsigned LongPktLen  = 158;
  localparam int unsigned LenOverhead = 4;
  localparam int unsigned MinLenByte  = 3;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_HDR2       = 2'd1,
    MODE_LEN        = 2'd2,
    MODE_IDLE_ALIAS = 2'd3
  } stpf_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE    = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_LINK    = 2'd2
  } stpf_cfg_idx_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } stpf_action_e;

  typedef struct packed {
    stpf_action_e action;
    logic [7:0]   byte_in;
  } stpf_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       packet_end;
    logic [8:0] packet_length;
  } stpf_out_t;

  typedef struct packed {
    stpf_mode_e  mode;
    logic [15:0] timeout;
    logic        link_active;
  } stpf_cfg_t;

endpackage

// File: src/stpf_in_stage.sv
// Input register of the framer: holds one accepted word until the decision
// stage takes it. Depends on stpf_pkg.
module stpf_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  stpf_pkg::stpf_in_t in_item_i,
  input  logic             take_i,
  output logic             valid_o,
  output stpf_pkg::stpf_in_t item_o
);
  import stpf_pkg::*;

  logic     valid_q, valid_d;
  stpf_in_t item_q;
  logic     accept;

  // Stall only while the held word cannot move on this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/stpf_framer.sv
// Framing decision and framer state: fill count, header position, short
// flag, stored header bytes and idle tick counter. Depends on stpf_pkg.
module stpf_framer #(
  parameter int unsigned BufferBytes = stpf_pkg::BufferBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  stpf_pkg::stpf_in_t  item_i,
  input  stpf_pkg::stpf_cfg_t cfg_i,
  output logic                res_valid_o,
  output stpf_pkg::stpf_out_t res_o
);
  import stpf_pkg::*;

  localparam int unsigned FillW = $clog2(BufferBytes + 1);
  localparam int unsigned CmpW  = (FillW > 9) ? FillW : 9;

  logic [FillW-1:0] fill_q, fill_d, fill_inc;
  logic [7:0]       hpos_q, hpos_d, hpos_inc;
  logic             short_q, short_d;
  logic [7:0]       first_q, first_d;
  logic [7:0]       lenb_q, lenb_d;
  logic [15:0]      idle_q, idle_d, idle_inc;
  logic [CmpW-1:0]  fill_ext;
  logic             idle_mode, hdr_end, len_end, pkt_end, full;
  logic [7:0]       b;

  assign b         = item_i.byte_in;
  assign fill_inc  = fill_q + FillW'(1);
  assign fill_ext  = CmpW'(fill_inc);
  assign hpos_inc  = hpos_q + 8'd1;
  assign idle_inc  = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
  assign idle_mode = (cfg_i.mode == MODE_IDLE) || (cfg_i.mode == MODE_IDLE_ALIAS);
  assign full      = (fill_ext == CmpW'(BufferBytes));
  assign first_d   = (fill_ext == CmpW'(1)) ? b : first_q;
  assign lenb_d    = (fill_ext == CmpW'(LenOverhead)) ? b : lenb_q;

  // Two-letter header: position within the packet and boundary decision.
  always_comb begin
    hpos_d  = hpos_inc;
    short_d = short_q;
    hdr_end = 1'b0;
    unique case (hpos_inc)
      8'd1: begin
        if (first_d == ChrL) begin
          short_d = 1'b1;
        end else if (first_d == ChrX) begin
          short_d = 1'b0;
        end else begin
          hpos_d  = '0;
          hdr_end = 1'b1;
        end
      end
      8'd2: begin
        if ((first_d == ChrL && b != ChrQ) || (first_d == ChrX && b != ChrX)) begin
          hpos_d  = '0;
          hdr_end = 1'b1;
        end
      end
      8'(ShortPktLen): begin
        hdr_end = 1'b1;
        if (short_q) begin
          hpos_d = '0;
        end
      end
      8'(LongPktLen): begin
        hpos_d  = '0;
        hdr_end = 1'b1;
      end
      default: begin
        hdr_end = (fill_ext == CmpW'(ShortPktLen));
      end
    endcase
  end

  // Length-prefixed header: check letters, then the length byte.
  always_comb begin
    unique case (fill_ext)
      CmpW'(1): len_end = (b != ChrM);
      CmpW'(2): len_end = (b != ChrA);
      CmpW'(3): len_end = (b != ChrX);
      CmpW'(4): len_end = (b < 8'(MinLenByte));
      default:  len_end = (fill_ext == CmpW'(lenb_d) + CmpW'(LenOverhead));
    endcase
  end

  always_comb begin
    fill_d      = fill_q;
    res_valid_o = 1'b0;
    pkt_end     = 1'b0;
    idle_d      = idle_q;
    res_o       = '0;
    if (item_i.action == ACT_TICK) begin
      if (idle_mode && fill_q != '0) begin
        idle_d = idle_inc;
        if (idle_inc >= cfg_i.timeout) begin
          pkt_end     = 1'b1;
          res_valid_o = 1'b1;
          fill_d      = '0;
          idle_d      = '0;
          res_o.packet_end    = 1'b1;
          res_o.packet_length = CmpW'(fill_q) > CmpW'(0) ? 9'(CmpW'(fill_q)) : 9'd0;
        end
      end
    end else if (cfg_i.link_active) begin
      res_valid_o = 1'b1;
      fill_d      = fill_inc;
      if (full) begin
        pkt_end = 1'b1;
      end else begin
        unique case (cfg_i.mode)
          MODE_HDR2: pkt_end = hdr_end;
          MODE_LEN:  pkt_end = len_end;
          default:   idle_d  = '0;
        endcase
      end
      res_o.byte_out   = b;
      res_o.byte_valid = 1'b1;
      if (pkt_end) begin
        fill_d              = '0;
        idle_d              = '0;
        res_o.packet_end    = 1'b1;
        res_o.packet_length = fill_ext[8:0];
      end
    end
  end

  logic write_en, hdr_en;
  assign write_en = advance_i && item_i.action == ACT_WRITE && cfg_i.link_active;
  assign hdr_en   = write_en && !full && cfg_i.mode == MODE_HDR2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      hpos_q  <= '0;
      short_q <= 1'b0;
      first_q <= '0;
      lenb_q  <= '0;
      idle_q  <= '0;
    end else begin
      if (advance_i) begin
        fill_q <= fill_d;
        idle_q <= idle_d;
      end
      if (write_en) begin
        first_q <= first_d;
        lenb_q  <= lenb_d;
      end
      if (hdr_en) begin
        hpos_q  <= hpos_d;
        short_q <= short_d;
      end
    end
  end

endmodule

// File: src/stpf_out_stage.sv
// Result register of the framer: holds one result word until the sink
// takes it. Depends on stpf_pkg.
module stpf_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  stpf_pkg::stpf_out_t res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stpf_pkg::stpf_out_t out_item_o
);
  import stpf_pkg::*;

  logic      valid_q, valid_d;
  stpf_out_t item_q;

  // Free when empty or when the held word leaves this cycle.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// File: src/serial_tx_packet_framer_core.sv
// Top level of the serial transmit packet framer: configuration registers,
// input register, framing decision and result register.
// Depends on stpf_pkg, stpf_in_stage, stpf_framer, stpf_out_stage.
//
//   channel | direction | handshake               | payload
//   in      | sink      | in_valid_i / in_stall_o | in_item_i (action, byte_in)
//   out     | source    | out_valid_o/out_stall_i | out_item_o (byte, flags, length)
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled; the input
// register and then the result register lie between acceptance and a result.
// Dropped writes and quiet ticks give no result but still pass the input register.
// Reset clears all framer state and loads the default configuration.
// A stalled output holds its word; the input stalls only when the input
// register is full and the result register cannot take its word.
module serial_tx_packet_framer_core #(
  parameter int unsigned BufferBytes = stpf_pkg::BufferBytesDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  stpf_pkg::stpf_in_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output stpf_pkg::stpf_out_t                out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [stpf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [stpf_pkg::CfgDataW-1:0]      cfg_data_i
);
  import stpf_pkg::*;

  stpf_cfg_t cfg_q;
  stpf_in_t  s1_item;
  stpf_out_t res;
  logic      s1_valid, out_free, advance, res_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= MODE_IDLE;
      cfg_q.timeout     <= 16'd25;
      cfg_q.link_active <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODE:    cfg_q.mode        <= stpf_mode_e'(cfg_data_i[1:0]);
        CFG_TIMEOUT: cfg_q.timeout     <= cfg_data_i;
        CFG_LINK:    cfg_q.link_active <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign advance = s1_valid && out_free;

  stpf_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .take_i     (out_free),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  stpf_framer #(
    .BufferBytes (BufferBytes)
  ) u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (s1_item),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  stpf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // A tick only produces a result when it closes a packet.
  a_tick_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.byte_valid |-> out_item_o.packet_end)
    else $error("tick result without packet end");

  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.packet_end |-> out_item_o.packet_length == 9'd0)
    else $error("length reported without packet end");

  // The input never stalls while the input register is empty.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid |-> !in_stall_o)
    else $error("input stalled with empty input register");

endmodule

// File: sim/serial_tx_packet_framer_core_test.sv
// Self-checking bench for serial_tx_packet_framer_core: drives write and tick words
// through all framing modes, predicts every result and compares it field by field.
// Depends on stpf_pkg and the framer RTL.
module serial_tx_packet_framer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stpf_pkg::*;

  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 8;

  class framer_scoreboard;
    int unsigned buffer_bytes;
    stpf_mode_e  mode;
    logic [15:0] timeout;
    logic        link_on;
    logic [8:0]  fill_count;
    logic [7:0]  hdr_pos;
    logic        short_pkt;
    logic [7:0]  first_byte;
    logic [7:0]  len_byte;
    logic [15:0] idle_ticks;
    stpf_out_t   expected_q[$];
    int unsigned failures;
    int unsigned words_seen;
    int unsigned results_seen;
    int unsigned packet_ends;

    function new(int unsigned depth);
      buffer_bytes = depth;
      mode         = MODE_IDLE;
      timeout      = 16'd25;
      link_on      = 1'b0;
      fill_count   = '0;
      hdr_pos      = '0;
      short_pkt    = 1'b0;
      first_byte   = '0;
      len_byte     = '0;
      idle_ticks   = '0;
      failures     = 0;
      words_seen   = 0;
      results_seen = 0;
      packet_ends  = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void load_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (stpf_cfg_idx_e'(idx))
        CFG_MODE:    mode = stpf_mode_e'(data[1:0]);
        CFG_TIMEOUT: timeout = data;
        CFG_LINK:    link_on = data[0];
        default: ;
      endcase
    endfunction

    // Two-letter header framing; advances the header position first.
    function bit hdr2_ends(logic [7:0] b);
      hdr_pos = hdr_pos + 8'd1;
      case (hdr_pos)
        8'd1: begin
          if (first_byte == ChrL) begin
            short_pkt = 1'b1;
          end else if (first_byte == ChrX) begin
            short_pkt = 1'b0;
          end else begin
            hdr_pos = '0;
            return 1'b1;
          end
          return 1'b0;
        end
        8'd2: begin
          if ((first_byte == ChrL && b != ChrQ) || (first_byte == ChrX && b != ChrX)) begin
            hdr_pos = '0;
            return 1'b1;
          end
          return 1'b0;
        end
        ShortPktLen: begin
          if (short_pkt) hdr_pos = '0;
          return 1'b1;
        end
        LongPktLen: begin
          hdr_pos = '0;
          return 1'b1;
        end
        default: return fill_count == ShortPktLen;
      endcase
    endfunction

    function bit len_ends(logic [7:0] b);
      case (fill_count)
        9'd1:    return b != ChrM;
        9'd2:    return b != ChrA;
        9'd3:    return b != ChrX;
        9'd4:    return b < MinLenByte;
        default: return fill_count == len_byte + LenOverhead;
      endcase
    endfunction

    function void note_word(stpf_in_t w);
      stpf_out_t r;
      bit ends;
      words_seen++;
      r = '0;
      ends = 1'b0;
      if (w.action == ACT_TICK) begin
        if ((mode == MODE_IDLE || mode == MODE_IDLE_ALIAS) && fill_count != 0) begin
          if (idle_ticks != 16'hFFFF) idle_ticks++;
          if (idle_ticks >= timeout) begin
            r.packet_end    = 1'b1;
            r.packet_length = fill_count;
            fill_count      = '0;
            idle_ticks      = '0;
            packet_ends++;
            expected_q.insert(expected_q.size(), r);
          end
        end
        return;
      end
      // drop writes while the link is down
      if (!link_on) return;
      fill_count++;
      if (fill_count == 9'd1) first_byte = w.byte_in;
      if (fill_count == 9'd4) len_byte = w.byte_in;
      if (fill_count >= buffer_bytes) begin
        ends = 1'b1;
      end else if (mode == MODE_HDR2) begin
        ends = hdr2_ends(w.byte_in);
      end else if (mode == MODE_LEN) begin
        ends = len_ends(w.byte_in);
      end else begin
        idle_ticks = '0;
      end
      r.byte_out   = w.byte_in;
      r.byte_valid = 1'b1;
      if (ends) begin
        r.packet_end    = 1'b1;
        r.packet_length = fill_count;
        fill_count      = '0;
        idle_ticks      = '0;
        packet_ends++;
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(stpf_out_t got);
      stpf_out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: byte_out %0d packet_end %0d packet_length %0d",
               got.byte_out, got.packet_end, got.packet_length);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      if (got.byte_out !== want.byte_out) begin
        $error("byte_out: expected %0d, got %0d", want.byte_out, got.byte_out);
        failures++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
        failures++;
      end
      if (got.packet_end !== want.packet_end) begin
        $error("packet_end: expected %0d, got %0d", want.packet_end, got.packet_end);
        failures++;
      end
      if (got.packet_length !== want.packet_length) begin
        $error("packet_length: expected %0d, got %0d", want.packet_length, got.packet_length);
        failures++;
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  stpf_in_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  stpf_out_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  bit                  steady = 1'b0;
  int unsigned         quiet_cycles = 0;
  stpf_in_t            script_q[$];
  framer_scoreboard    board = new(BufferBytesDef);

  serial_tx_packet_framer_core #(
    .BufferBytes(BufferBytesDef)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 35);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.load_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) board.note_word(in_item_i);
      if (out_valid_o && !out_stall_i) board.check_result(out_item_o);
    end
  end

  // Watchdog: count cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $error("no handshake for %0d cycles, %0d results outstanding",
             QuietLimit, board.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] b);
    stpf_in_t w;
    w.action  = ACT_WRITE;
    w.byte_in = b;
    script_q.insert(script_q.size(), w);
  endfunction

  function automatic void push_tick();
    stpf_in_t w;
    w.action  = ACT_TICK;
    w.byte_in = 8'($urandom_range(255));
    script_q.insert(script_q.size(), w);
  endfunction

  function automatic logic [7:0] header_letter();
    case ($urandom_range(4))
      0:       return ChrL;
      1:       return ChrQ;
      2:       return ChrX;
      3:       return ChrM;
      default: return ChrA;
    endcase
  endfunction

  // Payload byte with an occasional tick mixed in; ticks are quiet in header modes.
  function automatic void push_payload();
    if ($urandom_range(19) == 0) push_tick();
    push_byte(8'($urandom_range(255)));
  endfunction

  function automatic void add_idle_packet(logic [15:0] timeout);
    int unsigned n;
    int unsigned ticks;
    n = ($urandom_range(19) == 0) ? $urandom_range(270, 250) : $urandom_range(12, 1);
    repeat (n) push_byte(8'($urandom_range(255)));
    if (timeout <= 16) begin
      ticks = ($urandom_range(3) == 0) ? $urandom_range(timeout, 0)
                                       : timeout + $urandom_range(2);
    end else begin
      ticks = $urandom_range(5);
    end
    repeat (ticks) push_tick();
  endfunction

  function automatic void add_hdr2_packet();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  lead;
    pick = $urandom_range(99);
    if (pick < 45) begin
      push_byte(ChrL);
      push_byte(ChrQ);
      n = ShortPktLen - 2;
    end else if (pick < 65) begin
      push_byte(ChrX);
      push_byte(ChrX);
      n = LongPktLen - 2;
    end else if (pick < 85) begin
      // mostly a broken header: odd lead letter or a wrong second letter
      lead = $urandom_range(1) ? ChrL : ChrX;
      if ($urandom_range(3) == 0) lead = 8'($urandom_range(255));
      push_byte(lead);
      push_byte($urandom_range(1) ? header_letter() : 8'($urandom_range(255)));
      n = $urandom_range(6);
    end else begin
      n = $urandom_range(5, 1);
    end
    repeat (n) push_payload();
  endfunction

  function automatic void add_len_packet();
    int unsigned pick;
    int unsigned cut;
    logic [7:0]  len;
    pick = $urandom_range(99);
    if (pick < 65) begin
      push_byte(ChrM);
      push_byte(ChrA);
      push_byte(ChrX);
      pick = $urandom_range(19);
      if (pick == 0) len = 8'd255;
      else if (pick < 4) len = 8'($urandom_range(80, 25));
      else len = 8'($urandom_range(24, MinLenByte));
      push_byte(len);
      repeat (len) push_payload();
    end else if (pick < 85) begin
      // prefix cut short by a wrong byte or a too-short length
      cut = $urandom_range(3);
      if (cut > 0) push_byte(ChrM);
      if (cut > 1) push_byte(ChrA);
      if (cut > 2) push_byte(ChrX);
      if (cut == 3) push_byte(8'($urandom_range(MinLenByte - 1)));
      else push_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(5, 1)) push_payload();
    end
  endfunction

  function automatic void build_words(stpf_mode_e mode, logic [15:0] timeout, logic link,
                                      int unsigned budget);
    int unsigned stop;
    stop = script_q.size() + budget;
    while (script_q.size() < stop) begin
      if (!link) begin
        if ($urandom_range(1)) push_tick();
        else push_byte(8'($urandom_range(255)));
      end else begin
        case (mode)
          MODE_HDR2: add_hdr2_packet();
          MODE_LEN:  add_len_packet();
          default:   add_idle_packet(timeout);
        endcase
      end
    end
    // leave a packet half built so the next setting starts mid-packet
    if (link && $urandom_range(1)) begin
      push_byte(header_letter());
      push_byte(header_letter());
    end
  endfunction

  task automatic send_script();
    stpf_in_t w;
    while (script_q.size() != 0) begin
      w = script_q.pop_front();
      if (!steady) begin
        while ($urandom_range(99) < 35) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b1;
      in_item_i  <= w;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending() != 0) @(posedge clk_i);
    // quiet words leave no result but may still be in flight
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(stpf_cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_framing(stpf_mode_e mode, logic [15:0] timeout, logic link);
    write_cfg(CFG_MODE, CfgDataW'(mode));
    write_cfg(CFG_TIMEOUT, timeout);
    write_cfg(CFG_LINK, CfgDataW'(link));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(stpf_mode_e mode, logic [15:0] timeout, logic link,
                           int unsigned budget, bit calm);
    set_framing(mode, timeout, link);
    build_words(mode, timeout, link, budget);
    steady = calm;
    send_script();
    drain();
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: link down, writes drop and ticks stay quiet
    push_byte(8'h00);
    push_byte(8'hFF);
    push_tick();
    send_script();
    drain();

    // zero timeout closes the packet on the first tick
    set_framing(MODE_IDLE, 16'd0, 1'b1);
    push_byte(8'hFF);
    push_tick();
    push_tick();
    send_script();
    drain();

    // bad lead, then two good leads each with a wrong second letter
    set_framing(MODE_HDR2, 16'd25, 1'b1);
    push_byte(8'h20);
    push_byte(ChrL);
    push_byte(ChrX);
    push_byte(ChrX);
    push_byte(ChrQ);
    push_tick();
    send_script();
    drain();

    // length too short, broken prefix, then hold a pending byte
    set_framing(MODE_LEN, 16'hFFFF, 1'b1);
    push_byte(ChrM);
    push_byte(ChrA);
    push_byte(ChrX);
    push_byte(8'd2);
    push_byte(ChrM);
    push_byte(ChrQ);
    push_byte(ChrM);
    send_script();
    drain();

    // idle alias with the link down: the tick still closes the pending packet
    set_framing(MODE_IDLE_ALIAS, 16'd1, 1'b0);
    push_tick();
    push_byte(8'h7E);
    send_script();
    drain();

    run_phase(MODE_IDLE, 16'd3, 1'b1, 70, 1'b0);
    run_phase(MODE_HDR2, 16'd25, 1'b1, 120, 1'b0);
    run_phase(MODE_LEN, 16'd1, 1'b1, 110, 1'b0);
    run_phase(MODE_IDLE_ALIAS, 16'hFFFF, 1'b1, 140, 1'b0);
    run_phase(MODE_HDR2, 16'd9, 1'b1, 100, 1'b1);
    run_phase(MODE_IDLE, 16'd0, 1'b0, 30, 1'b0);
    run_phase(MODE_LEN, 16'd40, 1'b1, 70, 1'b0);
    run_phase(MODE_IDLE, 16'($urandom_range(12, 1)), 1'b1, 70, 1'b0);

    $display("Framer run: %0d words in idle, header and length modes, link up and down;",
             board.words_seen);
    $display("%0d results compared, %0d of them packet ends.",
             board.results_seen, board.packet_ends);
    if (board.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
